// File: hdl/heap_allocation_tracker_assert.svh
// Assertion macros for the heap allocation tracker.
`ifndef HEAP_ALLOCATION_TRACKER_ASSERT_SVH
`define HEAP_ALLOCATION_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define HAT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hat assertion failed");
// Next-cycle implication, sampled on clk, off during reset.
`define HAT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hat assertion failed");
`else
`define HAT_ASSERT_IMPL(lbl, ante, cons)
`define HAT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hdl/hat_pkg.sv
// Types and codes shared by the heap allocation tracker modules.
`timescale 1ns / 1ps
package hat_pkg;

	typedef enum logic [1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_FREE    = 2'd1,
		CMD_REALLOC = 2'd2,
		CMD_WMARK   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_NULL      = 2'd1,
		ST_FULL      = 2'd2,
		ST_UNTRACKED = 2'd3
	} status_t;

	// slot table write controls
	typedef struct packed {
		logic wr_mem;   // write address and size
		logic set_vld;  // mark slot occupied
		logic clr_vld;  // mark slot empty
	} slot_op_t;

	// usage counter controls
	typedef struct packed {
		logic apply;    // usage += add - sub
		logic raise;    // watermark follows usage if above
		logic copy;     // watermark takes usage
	} usage_op_t;

endpackage

// File: hdl/hat_slot_mem.sv
// Slot table: address and size memories with per-slot occupied bits.
`timescale 1ns / 1ps
module hat_slot_mem import hat_pkg::*; #(
	parameter int TABLE_DEPTH = 128,
	parameter int ADDR_WIDTH  = 32,
	parameter int SIZE_WIDTH  = 32,
	parameter int IW          = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [IW-1:0]         rd_idx,
	output logic                  vld_s1,
	output logic [ADDR_WIDTH-1:0] addr_s1,
	output logic [SIZE_WIDTH-1:0] size_s1,
	input  slot_op_t              wr_op,
	input  logic [IW-1:0]         wr_idx,
	input  logic [ADDR_WIDTH-1:0] wr_addr,
	input  logic [SIZE_WIDTH-1:0] wr_size
);

	logic [ADDR_WIDTH-1:0] addr_mem [TABLE_DEPTH];
	logic [SIZE_WIDTH-1:0] size_mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (wr_op.wr_mem) begin
			addr_mem[wr_idx] <= wr_addr;
			size_mem[wr_idx] <= wr_size;
		end
		if (rd_en) begin
			addr_s1 <= addr_mem[rd_idx];
			size_s1 <= size_mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (wr_op.set_vld)
				vld_q[wr_idx] <= 1'b1;
			else if (wr_op.clr_vld)
				vld_q[wr_idx] <= 1'b0;
			if (rd_en)
				vld_s1 <= vld_q[rd_idx];
		end
	end

endmodule

// File: hdl/hat_usage.sv
// Current usage and high watermark counters.
`timescale 1ns / 1ps
module hat_usage import hat_pkg::*; #(
	parameter int SIZE_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  usage_op_t             op,
	input  logic [SIZE_WIDTH-1:0] add_amt,
	input  logic [SIZE_WIDTH-1:0] sub_amt,
	output logic [SIZE_WIDTH-1:0] usage_q,
	output logic [SIZE_WIDTH-1:0] peak_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usage_q <= '0;
			peak_q  <= '0;
		end else begin
			// wraps modulo 2^SIZE_WIDTH
			if (op.apply)
				usage_q <= usage_q + add_amt - sub_amt;
			if (op.copy)
				peak_q <= usage_q;
			else if (op.raise && (usage_q > peak_q))
				peak_q <= usage_q;
		end
	end

endmodule

// File: hdl/heap_allocation_tracker.sv
// Top level of the heap allocation tracker: command sequencer and slot scan.
`timescale 1ns / 1ps
`include "heap_allocation_tracker_assert.svh"
// Tracks live heap blocks in a table of TABLE_DEPTH address/size slots.
// A command beat is taken when start is high and busy is low. Each command
// yields exactly one result beat: done is high for one cycle with status,
// usage_now and usage_peak valid in that cycle; there is no back-pressure,
// so the receiver must take the beat when it appears. Per command:
//  - null arguments and the watermark reset report without a scan (done in the
//    cycle after the accept edge).
//  - alloc, free and realloc scan the slot memory one slot per cycle
//    through its single read port; a hit reports after the commit and
//    watermark steps, a miss (table full / untracked) after the last slot.
// busy stays high for the whole scan; the table is empty after reset with
// no clearing pass. Usage and watermark wrap modulo 2^SIZE_WIDTH.
module heap_allocation_tracker import hat_pkg::*; #(
	parameter int TABLE_DEPTH = 128,
	parameter int ADDR_WIDTH  = 32,
	parameter int SIZE_WIDTH  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [31:0] addr,
	input  logic [31:0] new_addr,
	input  logic [31:0] size,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] usage_now,
	output logic [31:0] usage_peak
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY, S_PEAK} state_t;
	typedef enum logic [1:0] {OP_ALLOC, OP_FREE, OP_REALLOC} op_t;

	state_t                state_q;
	op_t                   op_q;
	logic [ADDR_WIDTH-1:0] key_q;      // address searched for; zero = empty slot
	logic [ADDR_WIDTH-1:0] wr_addr_q;  // address stored on a hit
	logic [SIZE_WIDTH-1:0] sz_q;
	logic [SIZE_WIDTH-1:0] old_q;      // size held by the hit slot
	logic [IW-1:0]         hit_idx_q;
	logic [CW-1:0]         scan_q;     // next slot to read
	logic                  rd_vld_s1;
	logic [IW-1:0]         idx_s1;
	logic                  raise_q;
	logic                  done_q;
	status_t               status_q;

	logic                  accept;
	logic                  rd_en;
	logic                  hit;
	logic                  slot_vld_s1;
	logic [ADDR_WIDTH-1:0] slot_addr_s1;
	logic [SIZE_WIDTH-1:0] slot_size_s1;
	slot_op_t              slot_op;
	usage_op_t             usage_op;
	logic [SIZE_WIDTH-1:0] add_amt;
	logic [SIZE_WIDTH-1:0] sub_amt;
	logic [SIZE_WIDTH-1:0] usage_q;
	logic [SIZE_WIDTH-1:0] peak_q;

	logic [ADDR_WIDTH-1:0] in_a;
	logic [ADDR_WIDTH-1:0] in_an;
	logic [SIZE_WIDTH-1:0] in_sz;
	cmd_t                  in_cmd;

	assign in_a   = ADDR_WIDTH'(addr);
	assign in_an  = ADDR_WIDTH'(new_addr);
	assign in_sz  = SIZE_WIDTH'(size);
	assign in_cmd = cmd_t'(command);

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// one read per cycle while slots remain
	assign rd_en = (state_q == S_SCAN) && (scan_q < CW'(TABLE_DEPTH));

	// a slot matches the key; an empty slot reads as address zero
	always_comb begin
		if (key_q == '0)
			hit = rd_vld_s1 && !slot_vld_s1;
		else
			hit = rd_vld_s1 && slot_vld_s1 && (slot_addr_s1 == key_q);
	end

	// commit of a hit
	always_comb begin
		slot_op  = '0;
		usage_op = '0;
		add_amt  = '0;
		sub_amt  = '0;
		if (state_q == S_APPLY) begin
			usage_op.apply = 1'b1;
			unique case (op_q)
				OP_ALLOC: begin
					slot_op.wr_mem  = 1'b1;
					slot_op.set_vld = 1'b1;
					add_amt         = sz_q;
				end
				OP_FREE: begin
					slot_op.clr_vld = 1'b1;
					sub_amt         = old_q;
				end
				OP_REALLOC: begin
					slot_op.wr_mem  = 1'b1;
					slot_op.set_vld = 1'b1;
					add_amt         = sz_q;
					sub_amt         = old_q;
				end
				default: ;
			endcase
		end
		usage_op.raise = (state_q == S_PEAK) && raise_q;
		usage_op.copy  = accept && (in_cmd == CMD_WMARK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= OP_ALLOC;
			scan_q    <= '0;
			rd_vld_s1 <= 1'b0;
			raise_q   <= 1'b0;
			done_q    <= 1'b0;
			status_q  <= ST_DONE;
		end else begin
			rd_vld_s1 <= rd_en && !hit;
			idx_s1    <= scan_q[IW-1:0];
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						scan_q    <= '0;
						sz_q      <= in_sz;
						// alloc stores addr; realloc stores new_addr
						wr_addr_q <= (in_cmd == CMD_ALLOC) ? in_a : in_an;
						// alloc, and realloc of a null old address, hunt for an empty slot
						key_q     <= ((in_cmd == CMD_ALLOC) ||
							((in_cmd == CMD_REALLOC) && (in_a == '0))) ? '0 : in_a;
						unique case (in_cmd)
							CMD_ALLOC: begin
								op_q <= OP_ALLOC;
								if (in_a == '0) begin
									done_q   <= 1'b1;
									status_q <= ST_NULL;
								end else begin
									done_q  <= 1'b0;
									state_q <= S_SCAN;
								end
							end
							CMD_FREE: begin
								op_q <= OP_FREE;
								if (in_a == '0) begin
									done_q   <= 1'b1;
									status_q <= ST_NULL;
								end else begin
									done_q  <= 1'b0;
									state_q <= S_SCAN;
								end
							end
							CMD_REALLOC: begin
								// C realloc: null old is alloc, size zero is free
								priority if (in_a == '0) begin
									op_q <= OP_ALLOC;
									if (in_an == '0) begin
										done_q   <= 1'b1;
										status_q <= ST_NULL;
									end else begin
										done_q  <= 1'b0;
										state_q <= S_SCAN;
									end
								end else if (in_sz == '0) begin
									op_q    <= OP_FREE;
									done_q  <= 1'b0;
									state_q <= S_SCAN;
								end else if (in_an == '0) begin
									done_q   <= 1'b1;
									status_q <= ST_NULL;
								end else begin
									op_q    <= OP_REALLOC;
									done_q  <= 1'b0;
									state_q <= S_SCAN;
								end
							end
							CMD_WMARK: begin
								done_q   <= 1'b1;
								status_q <= ST_DONE;
							end
							default: done_q <= 1'b0;
						endcase
					end else begin
						done_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (rd_en)
						scan_q <= scan_q + CW'(1);
					if (hit) begin
						hit_idx_q <= idx_s1;
						old_q     <= slot_size_s1;
						done_q    <= 1'b0;
						state_q   <= S_APPLY;
					end else if (rd_vld_s1 && (idx_s1 == IW'(TABLE_DEPTH - 1))) begin
						done_q   <= 1'b1;
						status_q <= (op_q == OP_ALLOC) ? ST_FULL : ST_UNTRACKED;
						state_q  <= S_IDLE;
					end else begin
						done_q <= 1'b0;
					end
				end
				S_APPLY: begin
					// the watermark only follows usage when it grew
					raise_q <= (op_q == OP_ALLOC) || ((op_q == OP_REALLOC) && (sz_q > old_q));
					done_q  <= 1'b0;
					state_q <= S_PEAK;
				end
				S_PEAK: begin
					done_q   <= 1'b1;
					status_q <= ST_DONE;
					state_q  <= S_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	hat_slot_mem #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.ADDR_WIDTH  (ADDR_WIDTH),
		.SIZE_WIDTH  (SIZE_WIDTH),
		.IW          (IW)
	) u_slot_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_idx  (scan_q[IW-1:0]),
		.vld_s1  (slot_vld_s1),
		.addr_s1 (slot_addr_s1),
		.size_s1 (slot_size_s1),
		.wr_op   (slot_op),
		.wr_idx  (hit_idx_q),
		.wr_addr (wr_addr_q),
		.wr_size (sz_q)
	);

	hat_usage #(
		.SIZE_WIDTH (SIZE_WIDTH)
	) u_usage (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (usage_op),
		.add_amt (add_amt),
		.sub_amt (sub_amt),
		.usage_q (usage_q),
		.peak_q  (peak_q)
	);

	assign done       = done_q;
	assign status     = status_q;
	assign usage_now  = 32'(usage_q);
	assign usage_peak = 32'(peak_q);

	// every accepted beat either reports at once or holds busy
	`HAT_ASSERT_NEXT(a_accept_progress, accept, done_q || busy)
	// the result beat is only shown once the sequencer is back in idle
	`HAT_ASSERT_IMPL(a_done_idle, done_q, state_q == S_IDLE)
	// a commit is always followed by the watermark step
	`HAT_ASSERT_NEXT(a_apply_peak, state_q == S_APPLY, state_q == S_PEAK)
	// usage moves only on a commit
	`HAT_ASSERT_NEXT(a_usage_hold, state_q != S_APPLY, $stable(usage_q))
	// the slot memory is never written while a scan reads it
	`HAT_ASSERT_IMPL(a_no_rw_overlap, slot_op.wr_mem, !rd_en)

endmodule
